// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the life generation stencil core.
// ----------------------------------------------------------------------------
package lgs_pkg;

	localparam int WORD_W        = 32;
	localparam int ROW_WORDS_DEF = 8;
	localparam int BIRTH_COUNT   = 3;
	localparam int SURVIVE_COUNT = 2;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t up;
		word_t mid;
		word_t low;
	} column_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		word_t next_cells;
		logic  last;
	} res_t;

endpackage

// ===== rtl/lgs_cell.sv =====
// ----------------------------------------------------------------------------
// lgs_cell
// One word slot of the two row lines; hands its words to the next slot.
// ----------------------------------------------------------------------------
module lgs_cell import lgs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  word_t     mid_in,
	input  word_t     up_in,
	output word_t     mid,
	output word_t     up
);

	word_t mid_q;
	word_t up_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= '0;
			up_q  <= '0;
		end else if (ctl.clear) begin
			mid_q <= '0;
			up_q  <= '0;
		end else if (ctl.shift) begin
			mid_q <= mid_in;
			up_q  <= up_in;
		end
	end

	assign mid = mid_q;
	assign up  = up_q;

endmodule

// ===== rtl/lgs_rule.sv =====
// ----------------------------------------------------------------------------
// lgs_rule
// B3/S23 update of the center word from a 3x3 block of words.
// ----------------------------------------------------------------------------
module lgs_rule import lgs_pkg::*; (
	input  column_t left,
	input  column_t center,
	input  column_t right,
	output word_t   next
);

	logic [WORD_W+1:0] ext_up;
	logic [WORD_W+1:0] ext_mid;
	logic [WORD_W+1:0] ext_low;

	assign ext_up  = {right.up[0],  center.up,  left.up[WORD_W-1]};
	assign ext_mid = {right.mid[0], center.mid, left.mid[WORD_W-1]};
	assign ext_low = {right.low[0], center.low, left.low[WORD_W-1]};

	for (genvar g = 0; g < WORD_W; g++) begin : g_bit
		logic [3:0] nbr;
		assign nbr = 4'(ext_up[g]) + 4'(ext_up[g+1]) + 4'(ext_up[g+2])
			+ 4'(ext_mid[g]) + 4'(ext_mid[g+2])
			+ 4'(ext_low[g]) + 4'(ext_low[g+1]) + 4'(ext_low[g+2]);
		assign next[g] = (nbr == 4'(BIRTH_COUNT))
			|| (ext_mid[g+1] && (nbr == 4'(SURVIVE_COUNT)));
	end

endmodule

// ===== rtl/lgs_outq.sv =====
// ----------------------------------------------------------------------------
// lgs_outq
// Small result queue between the stencil and the result channel.
// ----------------------------------------------------------------------------
module lgs_outq import lgs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  res_t             wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output res_t             rd_data,
	output logic [OQ_CW-1:0] count
);

	res_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             rd_en;

	assign rd_valid = (count_q != '0);
	assign rd_en    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	overflow_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |-> (count_q != OQ_CW'(OQ_DEPTH)))
		else $error("result queue overflow");

	underflow_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !rd_en)
		else $error("result queue underflow");

	count_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("result queue count slip");

endmodule

// ===== rtl/life_generation_stencil_core.sv =====
// ----------------------------------------------------------------------------
// life_generation_stencil_core
// One B3/S23 generation over a raster stream of 32-cell row words.
//
//   channel | signals                          | beat
//   item    | item_valid/ready, cells, frame_end | one current-generation word
//   result  | result_valid/ready, next_cells, last | one next-generation word
//
// One item beat per cycle while streaming; results run about one row behind.
// The row lines are a chain of ROW_WORDS cells shifted once per word.
// A frame_end beat starts a flush of up to ROW_WORDS+1 internal zero words
// plus a clear step, during which item_ready is low.
// arst_n clears all row lines, the window and the result queue.
// item_ready drops while three or more result beats are queued or pending.
// ----------------------------------------------------------------------------
module life_generation_stencil_core import lgs_pkg::*; #(
	parameter int ROW_WORDS = ROW_WORDS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  word_t cells,
	input  logic  frame_end,
	output logic  result_valid,
	input  logic  result_ready,
	output word_t next_cells,
	output logic  last
);

	localparam int            PW       = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam logic [PW-1:0] LAST_POS = PW'(ROW_WORDS - 1);

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_FLUSH = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]    state_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] p0_q;
	logic          seen_q;
	logic          zero_row_q;
	logic          tail_pend_q;
	logic          tail_last_q;
	column_t       win_prev_q;
	column_t       win_cur_q;

	logic             room;
	logic             item_fire;
	logic             flush_push;
	logic             push;
	logic             at_end;
	logic             main_res;
	logic             tail_set;
	logic             last_main;
	logic             zr_flush;
	logic [PW-1:0]    stop_pos;
	word_t            in_word;
	column_t          cur;
	column_t          rule_right;
	word_t            rule_next;
	res_t             wr_data;
	res_t             rd_data;
	logic             wr_en;
	logic [OQ_CW-1:0] oq_count;
	cell_ctl_t        cell_ctl;

	word_t mid_w [ROW_WORDS];
	word_t up_w  [ROW_WORDS];

	assign room = ({1'b0, oq_count} + (OQ_CW + 1)'(tail_pend_q))
		<= (OQ_CW + 1)'(OQ_DEPTH - 2);

	assign item_ready = (state_q == ST_RUN) && room;
	assign item_fire  = item_valid && item_ready;
	assign flush_push = (state_q == ST_FLUSH) && room;
	assign push       = item_fire || flush_push;
	assign in_word    = item_fire ? cells : '0;
	assign at_end     = (pos_q == LAST_POS);

	assign cell_ctl.shift = push;
	assign cell_ctl.clear = (state_q == ST_DRAIN);

	for (genvar k = 0; k < ROW_WORDS; k++) begin : g_cell
		word_t mid_in;
		word_t up_in;
		if (k == 0) begin : g_head
			assign mid_in = in_word;
			assign up_in  = mid_w[ROW_WORDS-1];
		end else begin : g_body
			assign mid_in = mid_w[k-1];
			assign up_in  = up_w[k-1];
		end
		lgs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cell_ctl),
			.mid_in (mid_in),
			.up_in  (up_in),
			.mid    (mid_w[k]),
			.up     (up_w[k])
		);
	end

	assign cur.up  = up_w[ROW_WORDS-1];
	assign cur.mid = mid_w[ROW_WORDS-1];
	assign cur.low = in_word;

	// the row tail word reuses the window with a dead right column
	assign rule_right = tail_pend_q ? '0 : cur;

	lgs_rule u_rule (
		.left   (win_prev_q),
		.center (win_cur_q),
		.right  (rule_right),
		.next   (rule_next)
	);

	assign zr_flush  = (state_q == ST_FLUSH) && zero_row_q;
	assign stop_pos  = (p0_q == LAST_POS) ? LAST_POS : p0_q + 1'b1;
	assign main_res  = push && seen_q && (pos_q != '0);
	assign last_main = flush_push && zero_row_q && (pos_q == stop_pos)
		&& (p0_q != LAST_POS);
	assign tail_set  = push && seen_q && at_end && !(zr_flush && (p0_q != LAST_POS));

	assign wr_en              = main_res || tail_pend_q;
	assign wr_data.next_cells = rule_next;
	assign wr_data.last       = tail_pend_q ? tail_last_q : last_main;

	lgs_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.rd_valid (result_valid),
		.rd_ready (result_ready),
		.rd_data  (rd_data),
		.count    (oq_count)
	);

	assign next_cells = rd_data.next_cells;
	assign last       = rd_data.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			pos_q       <= '0;
			p0_q        <= '0;
			seen_q      <= 1'b0;
			zero_row_q  <= 1'b0;
			tail_pend_q <= 1'b0;
			tail_last_q <= 1'b0;
			win_prev_q  <= '0;
			win_cur_q   <= '0;
		end else begin
			tail_pend_q <= tail_set;
			tail_last_q <= zr_flush && (p0_q == LAST_POS);
			if (push) begin
				pos_q      <= at_end ? '0 : pos_q + 1'b1;
				win_prev_q <= (pos_q == '0) ? '0 : win_cur_q;
				win_cur_q  <= cur;
				if (at_end) begin
					seen_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_RUN: begin
					if (item_fire && frame_end) begin
						state_q    <= ST_FLUSH;
						p0_q       <= pos_q;
						zero_row_q <= at_end;
					end
				end
				ST_FLUSH: begin
					if (flush_push) begin
						if (zero_row_q && (pos_q == stop_pos)) begin
							state_q <= ST_DRAIN;
						end else if (at_end) begin
							zero_row_q <= 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					state_q    <= ST_RUN;
					pos_q      <= '0;
					seen_q     <= 1'b0;
					zero_row_q <= 1'b0;
					win_prev_q <= '0;
					win_cur_q  <= '0;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	one_write_chk: assert property (@(posedge clk) disable iff (!arst_n)
		!(main_res && tail_pend_q))
		else $error("row tail collides with a stencil result");

	tail_pos_chk: assert property (@(posedge clk) disable iff (!arst_n)
		tail_pend_q |-> (pos_q == '0))
		else $error("row tail pending off a row boundary");

	drain_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_RUN) && !tail_pend_q)
		else $error("clear cycle did not return to streaming");

	last_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_data.last) |=> (state_q == ST_RUN) || (state_q == ST_DRAIN))
		else $error("final word written while flush still running");

endmodule
